>>> rtl/dsdft_pkg.sv
package dsdft_pkg;

    // Default sizes and register reset
    localparam int NUM_BINS_DEF   = 16;
    localparam int RING_DEPTH_DEF = 256;
    localparam logic [15:0] DAMP_RESET = 16'd65529;

    // Operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Magnitude unit widths
    localparam int ROOT_W = 40;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 4;
    localparam int CNT_W  = $clog2(ROOT_W);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RDC,
        S_RDR,
        S_MUL,
        S_SQRT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] sample;
        logic [3:0]         bin_index;
        logic signed [15:0] cos_step;
        logic signed [15:0] sin_step;
        logic signed [15:0] cos_window;
        logic signed [15:0] sin_window;
        logic [7:0]         window_len;
    } t_in_data;

    typedef struct packed {
        logic [3:0]         out_bin;
        logic [39:0]        magnitude;
        logic signed [47:0] real_part;
        logic signed [47:0] imag_part;
        logic               last;
    } t_out_data;

    typedef struct packed {
        logic signed [15:0] cs;
        logic signed [15:0] ss;
        logic signed [15:0] cw;
        logic signed [15:0] sw;
        logic [7:0]         win;
    } t_coef;

endpackage

>>> rtl/dsdft_in_if.sv
interface dsdft_in_if;
    logic                valid;
    logic                ready;
    dsdft_pkg::t_in_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/dsdft_out_if.sv
interface dsdft_out_if;
    logic                 valid;
    logic                 ready;
    dsdft_pkg::t_out_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/dsdft_cfg_if.sv
interface dsdft_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/damped_sliding_dft_bins.sv
// A sample item yields one result per bin: per bin, 2 memory reads, 15 shared
//   multiplier steps, the bit-serial square root and 1 emit, which waits on output stall.
// A new sample waits until the last bin of the one before is emitted, as the single
//   multiplier and the bit-serial square root work bin by bin. A load item keeps it idle.
// A clear item and reset both start a sweep over the whole sample ring that zeroes it;
//   input is not taken during the sweep. Reset also sets damping to 65529.
module damped_sliding_dft_bins #(
    parameter int NUM_BINS   = dsdft_pkg::NUM_BINS_DEF,
    parameter int RING_DEPTH = dsdft_pkg::RING_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dsdft_in_if.sink     i_in,
    dsdft_cfg_if.sink    i_cfg,
    dsdft_out_if.source  o_out
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int LW = ((AW > 8) ? AW : 8) + 1;

    // Multiplier step schedule
    localparam logic [3:0] K_VCW  = 4'd0;
    localparam logic [3:0] K_VSW  = 4'd1;
    localparam logic [3:0] K_TRD  = 4'd2;
    localparam logic [3:0] K_TID  = 4'd3;
    localparam logic [3:0] K_RC   = 4'd4;
    localparam logic [3:0] K_IS   = 4'd5;
    localparam logic [3:0] K_RS   = 4'd6;
    localparam logic [3:0] K_IC   = 4'd7;
    localparam logic [3:0] K_A0   = 4'd8;
    localparam logic [3:0] K_A1   = 4'd9;
    localparam logic [3:0] K_A2   = 4'd10;
    localparam logic [3:0] K_B0   = 4'd11;
    localparam logic [3:0] K_B1   = 4'd12;
    localparam logic [3:0] K_B2   = 4'd13;
    localparam logic [3:0] K_LAST = 4'd14;

    function automatic logic signed [47:0] sat48(input logic signed [67:0] x);
        if (x > 68'sh7FFF_FFFF_FFFF) begin
            sat48 = 48'sh7FFF_FFFF_FFFF;
        end else if (x < -68'sh8000_0000_0000) begin
            sat48 = 48'sh8000_0000_0000;
        end else begin
            sat48 = x[47:0];
        end
    endfunction

    dsdft_pkg::t_state r_state, n_state;
    logic [3:0]          r_k;
    logic [BW-1:0]       r_bin;
    logic [AW-1:0]       r_wp;
    logic [AW-1:0]       r_clr;
    logic signed [15:0]  r_sample;
    logic [15:0]         r_damp;
    logic [NUM_BINS-1:0] r_cvalid;
    logic [NUM_BINS-1:0] r_avalid;

    // Memories and their read registers
    logic signed [15:0]  r_ring_mem [RING_DEPTH];
    dsdft_pkg::t_coef    r_coef_mem [NUM_BINS];
    logic signed [47:0]  r_accr_mem [NUM_BINS];
    logic signed [47:0]  r_acci_mem [NUM_BINS];
    logic signed [15:0]  r_ring_q;
    dsdft_pkg::t_coef    r_coef_q;
    logic signed [47:0]  r_accr_q, r_acci_q;
    logic                r_cv_q, r_av_q;

    // Work registers
    logic signed [47:0]  r_tr, r_ti, r_nr, r_ni, r_accr_n, r_acci_n;
    logic signed [65:0]  r_p5;
    logic [79:0]         r_sq;
    dsdft_pkg::t_out_data r_out;
    logic                r_out_valid;

    logic                w_in_fire;
    logic                w_emit;
    logic                w_bin_last;
    logic signed [15:0]  w_cs, w_ss, w_cw, w_sw;
    logic [7:0]          w_win;
    logic signed [47:0]  w_accr, w_acci, w_acci_new;
    logic [LW-1:0]       w_dl, w_wp_ext, w_pos_ext;
    logic [AW-1:0]       w_pos;
    logic [47:0]         w_abs_r, w_abs_i, w_mag_a, w_mag_b;
    logic signed [48:0]  w_ma;
    logic signed [16:0]  w_mb;
    logic signed [65:0]  w_prod;
    logic                w_sq_start;
    logic [79:0]         w_rad;
    logic                w_sq_done;
    logic [39:0]         w_root;

    assign i_in.ready  = (r_state == dsdft_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_bin_last  = (r_bin == BW'(NUM_BINS - 1));
    assign w_emit      = (r_state == dsdft_pkg::S_EMIT) && (!r_out_valid || o_out.ready);

    // Coefficients of a bin never loaded read as zero, window length 1; cleared accumulators read as zero
    assign w_cs   = r_cv_q ? r_coef_q.cs : '0;
    assign w_ss   = r_cv_q ? r_coef_q.ss : '0;
    assign w_cw   = r_cv_q ? r_coef_q.cw : '0;
    assign w_sw   = r_cv_q ? r_coef_q.sw : '0;
    assign w_win  = r_cv_q ? r_coef_q.win : 8'd1;
    assign w_accr = r_av_q ? r_accr_q : '0;
    assign w_acci = r_av_q ? r_acci_q : '0;

    // Delay clamp and ring read position
    always_comb begin
        w_dl = LW'(w_win);
        if (w_dl == '0) begin
            w_dl = LW'(1);
        end
        if (w_dl > LW'(RING_DEPTH - 1)) begin
            w_dl = LW'(RING_DEPTH - 1);
        end
        w_wp_ext = LW'(r_wp);
        if (w_wp_ext >= w_dl) begin
            w_pos_ext = w_wp_ext - w_dl;
        end else begin
            w_pos_ext = w_wp_ext + LW'(RING_DEPTH) - w_dl;
        end
        w_pos = w_pos_ext[AW-1:0];
    end

    // Magnitude operands: integer parts of |acc|
    assign w_abs_r = r_accr_n[47] ? 48'(-r_accr_n) : 48'(r_accr_n);
    assign w_abs_i = r_acci_n[47] ? 48'(-r_acci_n) : 48'(r_acci_n);
    assign w_mag_a = w_abs_r >> 8;
    assign w_mag_b = w_abs_i >> 8;

    assign w_acci_new = sat48((68'(r_p5) + 68'(w_prod) + 68'sd16384) >>> 15);

    // Operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_k)
            K_VCW: begin w_ma = 49'(r_ring_q); w_mb = 17'(w_cw); end
            K_VSW: begin w_ma = 49'(r_ring_q); w_mb = 17'(w_sw); end
            K_TRD: begin w_ma = 49'(r_tr);     w_mb = {1'b0, r_damp}; end
            K_TID: begin w_ma = 49'(r_ti);     w_mb = {1'b0, r_damp}; end
            K_RC:  begin w_ma = 49'(r_nr);     w_mb = 17'(w_cs); end
            K_IS:  begin w_ma = 49'(r_ni);     w_mb = 17'(w_ss); end
            K_RS:  begin w_ma = 49'(r_nr);     w_mb = 17'(w_ss); end
            K_IC:  begin w_ma = 49'(r_ni);     w_mb = 17'(w_cs); end
            K_A0:  begin w_ma = {1'b0, w_mag_a}; w_mb = {1'b0, w_mag_a[15:0]}; end
            K_A1:  begin w_ma = {1'b0, w_mag_a}; w_mb = {1'b0, w_mag_a[31:16]}; end
            K_A2:  begin w_ma = {1'b0, w_mag_a}; w_mb = {1'b0, w_mag_a[47:32]}; end
            K_B0:  begin w_ma = {1'b0, w_mag_b}; w_mb = {1'b0, w_mag_b[15:0]}; end
            K_B1:  begin w_ma = {1'b0, w_mag_b}; w_mb = {1'b0, w_mag_b[31:16]}; end
            K_B2:  begin w_ma = {1'b0, w_mag_b}; w_mb = {1'b0, w_mag_b[47:32]}; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    dsdft_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    assign w_sq_start = (r_state == dsdft_pkg::S_MUL) && (r_k == K_LAST);
    assign w_rad      = r_sq + (80'(w_prod[55:0]) << 32);

    dsdft_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (w_rad),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsdft_pkg::S_CLR: begin
                if (r_clr == AW'(RING_DEPTH - 1)) begin
                    n_state = dsdft_pkg::S_IDLE;
                end
            end
            dsdft_pkg::S_IDLE: begin
                if (w_in_fire && i_in.data.operation == dsdft_pkg::OP_ADD) begin
                    n_state = dsdft_pkg::S_RDC;
                end else if (w_in_fire && i_in.data.operation == dsdft_pkg::OP_CLEAR) begin
                    n_state = dsdft_pkg::S_CLR;
                end
            end
            dsdft_pkg::S_RDC: n_state = dsdft_pkg::S_RDR;
            dsdft_pkg::S_RDR: n_state = dsdft_pkg::S_MUL;
            dsdft_pkg::S_MUL: begin
                if (r_k == K_LAST) begin
                    n_state = dsdft_pkg::S_SQRT;
                end
            end
            dsdft_pkg::S_SQRT: begin
                if (w_sq_done) begin
                    n_state = dsdft_pkg::S_EMIT;
                end
            end
            dsdft_pkg::S_EMIT: begin
                if (w_emit) begin
                    n_state = w_bin_last ? dsdft_pkg::S_IDLE : dsdft_pkg::S_RDC;
                end
            end
            default: n_state = dsdft_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsdft_pkg::S_CLR;
            r_clr       <= '0;
            r_k         <= '0;
            r_bin       <= '0;
            r_wp        <= '0;
            r_damp      <= dsdft_pkg::DAMP_RESET;
            r_cvalid    <= '0;
            r_avalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_damp <= i_cfg.data;
            end
            if (r_state == dsdft_pkg::S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_in_fire) begin
                if (i_in.data.operation == dsdft_pkg::OP_LOAD
                    && int'(i_in.data.bin_index) < NUM_BINS) begin
                    r_cvalid[BW'(i_in.data.bin_index)] <= 1'b1;
                end
                if (i_in.data.operation == dsdft_pkg::OP_CLEAR) begin
                    r_clr    <= '0;
                    r_avalid <= '0;
                end
                r_bin <= '0;
            end
            if (r_state == dsdft_pkg::S_RDR) begin
                r_k <= '0;
            end else if (r_state == dsdft_pkg::S_MUL) begin
                r_k <= r_k + 1'b1;
            end
            if (r_state == dsdft_pkg::S_MUL && r_k == K_A0) begin
                r_avalid[r_bin] <= 1'b1;
            end
            // Output register: a held result is freed by its transfer
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_bin       <= w_bin_last ? '0 : r_bin + 1'b1;
                if (w_bin_last) begin
                    r_wp <= (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample ring: clearing sweep, write after last bin, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == dsdft_pkg::S_CLR) begin
            r_ring_mem[r_clr] <= '0;
        end else if (w_emit && w_bin_last) begin
            r_ring_mem[r_wp] <= r_sample;
        end
        if (r_state == dsdft_pkg::S_RDR) begin
            r_ring_q <= r_ring_mem[w_pos];
        end
    end

    // Coefficient memory
    always_ff @(posedge i_clk) begin
        if (w_in_fire && i_in.data.operation == dsdft_pkg::OP_LOAD
            && int'(i_in.data.bin_index) < NUM_BINS) begin
            r_coef_mem[BW'(i_in.data.bin_index)] <= '{cs: i_in.data.cos_step,
                ss: i_in.data.sin_step, cw: i_in.data.cos_window,
                sw: i_in.data.sin_window, win: i_in.data.window_len};
        end
        if (r_state == dsdft_pkg::S_RDC) begin
            r_coef_q <= r_coef_mem[r_bin];
            r_cv_q   <= r_cvalid[r_bin];
        end
    end

    // Accumulator memories
    always_ff @(posedge i_clk) begin
        if (r_state == dsdft_pkg::S_MUL && r_k == K_A0) begin
            r_accr_mem[r_bin] <= r_accr_n;
            r_acci_mem[r_bin] <= w_acci_new;
        end
        if (r_state == dsdft_pkg::S_RDC) begin
            r_accr_q <= r_accr_mem[r_bin];
            r_acci_q <= r_acci_mem[r_bin];
            r_av_q   <= r_avalid[r_bin];
        end
    end

    // Datapath: each step consumes the registered product issued in the step before
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_sample <= i_in.data.sample;
        end
        if (r_state == dsdft_pkg::S_MUL) begin
            case (r_k)
                K_VSW: r_tr <= sat48(68'(w_accr) - ((68'(w_prod) + 68'sd64) >>> 7)
                                     + (68'(r_sample) <<< 8));
                K_TRD: r_ti <= sat48(68'(w_acci) - ((68'(w_prod) + 68'sd64) >>> 7));
                K_TID: r_nr <= sat48((68'(w_prod) + 68'sd32768) >>> 16);
                K_RC:  r_ni <= sat48((68'(w_prod) + 68'sd32768) >>> 16);
                K_IS:  r_p5 <= w_prod;
                K_RS:  r_accr_n <= sat48((68'(r_p5) - 68'(w_prod) + 68'sd16384) >>> 15);
                K_IC:  r_p5 <= w_prod;
                K_A0:  r_acci_n <= w_acci_new;
                K_A1:  r_sq <= 80'(w_prod[55:0]);
                K_A2:  r_sq <= r_sq + (80'(w_prod[55:0]) << 16);
                K_B0:  r_sq <= r_sq + (80'(w_prod[55:0]) << 32);
                K_B1:  r_sq <= r_sq + 80'(w_prod[55:0]);
                K_B2:  r_sq <= r_sq + (80'(w_prod[55:0]) << 16);
                default: r_sq <= r_sq;
            endcase
        end
        if (w_emit) begin
            r_out.out_bin   <= 4'(r_bin);
            r_out.magnitude <= w_root;
            r_out.real_part <= r_accr_n;
            r_out.imag_part <= r_acci_n;
            r_out.last      <= w_bin_last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Assertions
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.data.operation == dsdft_pkg::OP_ADD) |=> !i_in.ready)
        else $error("input taken while a sample is in work");
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_bin) < NUM_BINS)
        else $error("bin counter out of range");
    a_root_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> r_state == dsdft_pkg::S_SQRT)
        else $error("square root finished outside its wait");
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_out))
        else $error("held result overwritten");
endmodule

>>> rtl/dsdft_mul.sv
// Shared signed multiplier, product registered
module dsdft_mul (
    input  logic                i_clk,
    input  logic signed [48:0]  i_a,
    input  logic signed [16:0]  i_b,
    output logic signed [65:0]  o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 66'(i_a) * 66'(i_b);
    end

    assign o_p = r_p;
endmodule

>>> rtl/dsdft_sqrt.sv
// Restoring integer square root, one result bit per cycle
module dsdft_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dsdft_pkg::RAD_W-1:0]    i_rad,
    output logic                           o_done,
    output logic [dsdft_pkg::ROOT_W-1:0]   o_root
);
    localparam int RW = dsdft_pkg::ROOT_W;
    localparam int AW = dsdft_pkg::RAD_W;
    localparam int MW = dsdft_pkg::REM_W;
    localparam int CW = dsdft_pkg::CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_rad;
    logic [MW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [MW-1:0] n_rem;
    logic [RW-1:0] n_root;
    logic [MW-1:0] w_shift;
    logic [MW-1:0] w_trial;

    // Bring down two radicand bits, try root*4+1
    always_comb begin
        w_shift = {r_rem[MW-3:0], r_rad[AW-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        if (w_shift >= w_trial) begin
            n_rem  = w_shift - w_trial;
            n_root = {r_root[RW-2:0], 1'b1};
        end else begin
            n_rem  = w_shift;
            n_root = {r_root[RW-2:0], 1'b0};
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(RW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
